>>> sv/ufl_pkg.sv
// shared types, constants and helpers of the udp flow tracker
package ufl_pkg;

    localparam int FLOW_ENTRIES_DEF = 32;
    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd2;

    localparam logic [31:0] HALF_TIMEOUT_RST = 32'd60;
    localparam logic [31:0] FULL_TIMEOUT_RST = 32'd180;
    localparam logic [31:0] CHECK_INTERVAL_RST = 32'd1;

    typedef enum logic [1:0] {
        KIND_DELETED   = 2'd0,
        KIND_CREATED   = 2'd1,
        KIND_COUNTED   = 2'd2,
        KIND_UNTRACKED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SW_RD,
        ST_SW_CHK,
        ST_LK_RD,
        ST_LK_CHK,
        ST_LK_DONE,
        ST_UPD,
        ST_FIN
    } back_state_t;

    typedef struct packed {
        logic [31:0] half_timeout;
        logic [31:0] full_timeout;
    } tmo_t;

    typedef struct packed {
        logic        sweep;
        logic        udp;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [31:0] time_sec;
        logic [15:0] pkt_length;
    } cmd_t;

    typedef struct packed {
        logic [63:0] addrs;
        logic [31:0] ports;
        logic        rev;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [31:0] first;
        logic [31:0] last;
    } ent_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic        full;
        logic        rev;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [31:0] first;
        logic [31:0] last_seen;
        logic        last;
    } res_t;

    function automatic logic [47:0] sat_add_bytes(logic [47:0] b, logic [15:0] len);
        logic [48:0] sum;
        sum = {1'b0, b} + {33'd0, len};
        return sum[48] ? {48{1'b1}} : sum[47:0];
    endfunction

    function automatic logic [31:0] sat_inc_packets(logic [31:0] p);
        return (p == {32{1'b1}}) ? p : p + 32'd1;
    endfunction

endpackage

>>> sv/ufl_front.sv
// front end: config registers, aging trigger and packet classification
module ufl_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ufl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            has_ip,
    input  logic                            has_udp,
    input  logic [31:0]                     src_ip,
    input  logic [15:0]                     src_port,
    input  logic [31:0]                     dst_ip,
    input  logic [15:0]                     dst_port,
    input  logic [31:0]                     time_sec,
    input  logic [15:0]                     pkt_length,
    input  logic                            q_full,
    output logic                            q_push,
    output ufl_pkg::cmd_t                   q_data,
    output ufl_pkg::tmo_t                   tmo
);
    import ufl_pkg::*;

    logic [31:0] half_reg;
    logic [31:0] full_reg;
    logic [31:0] intv_reg;
    logic [31:0] lct_reg;
    logic [31:0] lct_next;
    logic        accept;
    logic        sweep;
    logic        udp;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    assign sweep = (intv_reg != 32'd0) && (time_sec >= lct_reg)
                   && ((time_sec - lct_reg) >= intv_reg);
    assign udp   = has_ip && has_udp;

    assign lct_next = (accept && sweep) ? time_sec : lct_reg;
    assign q_push   = accept && (sweep || udp);

    always_comb
    begin
        q_data.sweep      = sweep;
        q_data.udp        = udp;
        q_data.src_ip     = src_ip;
        q_data.src_port   = src_port;
        q_data.dst_ip     = dst_ip;
        q_data.dst_port   = dst_port;
        q_data.time_sec   = time_sec;
        q_data.pkt_length = pkt_length;
        tmo.half_timeout  = half_reg;
        tmo.full_timeout  = full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_TIMEOUT_RST;
            full_reg <= FULL_TIMEOUT_RST;
            intv_reg <= CHECK_INTERVAL_RST;
            lct_reg  <= 32'd0;
        end
        else
        begin
            lct_reg <= lct_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HALF_TIMEOUT:   half_reg <= cfg_data;
                    CFG_FULL_TIMEOUT:   full_reg <= cfg_data;
                    CFG_CHECK_INTERVAL: intv_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

endmodule

>>> sv/ufl_queue.sv
// short queue of classified packets between front and back
module ufl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ufl_pkg::cmd_t push_data,
    input  logic          pop,
    output ufl_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import ufl_pkg::*;

    cmd_t           data_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full     = (count_reg == (QAW+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/ufl_back.sv
// back end: flow table, aging sweep, lookup, update and result register
module ufl_back #(
    parameter int FLOW_ENTRIES = ufl_pkg::FLOW_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ufl_pkg::tmo_t tmo,
    input  logic          q_empty,
    input  ufl_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_stall,
    output ufl_pkg::res_t res
);
    import ufl_pkg::*;

    localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);

    back_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    cmd_t          cur_reg, cur_next;
    logic          e_found_reg, e_found_next;
    logic [AW-1:0] e_idx_reg, e_idx_next;
    logic          r_found_reg, r_found_next;
    logic [AW-1:0] r_idx_reg, r_idx_next;
    ent_t          hit_reg, hit_next;
    res_t          pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    res_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic [FLOW_ENTRIES-1:0] valid_reg, valid_next;

    ent_t          mem [FLOW_ENTRIES];
    logic          full_reg [FLOW_ENTRIES];
    ent_t          rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    ent_t          mem_wd;
    logic          fwe;
    logic [AW-1:0] fwa;
    logic          fwd;
    logic          rfwe;

    logic          emit;
    logic          flush;
    res_t          new_res;
    logic          out_free;
    logic          can_emit;
    logic          at_end;
    logic [AW-1:0] idx;
    logic          free_found;
    logic [AW-1:0] free_idx;
    logic [63:0]   key_a, rkey_a;
    logic [31:0]   key_p, rkey_p;
    logic [31:0]   lim;
    logic          expired;
    ent_t          upd;

    assign out_free = !out_valid_reg || !res_stall;
    assign can_emit = !pend_valid_reg || out_free;
    assign at_end   = (idx_reg == CW'(FLOW_ENTRIES));
    assign idx      = idx_reg[AW-1:0];
    assign rd_addr  = at_end ? '0 : idx;
    assign key_a    = {cur_reg.src_ip, cur_reg.dst_ip};
    assign key_p    = {cur_reg.src_port, cur_reg.dst_port};
    assign rkey_a   = {cur_reg.dst_ip, cur_reg.src_ip};
    assign rkey_p   = {cur_reg.dst_port, cur_reg.src_port};
    assign lim      = full_reg[idx] ? tmo.full_timeout : tmo.half_timeout;
    assign expired  = (cur_reg.time_sec >= rd_data_reg.last)
                      && ((cur_reg.time_sec - rd_data_reg.last) >= lim);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = FLOW_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb
    begin
        upd         = hit_reg;
        upd.last    = cur_reg.time_sec;
        upd.packets = sat_inc_packets(hit_reg.packets);
        upd.bytes   = sat_add_bytes(hit_reg.bytes, cur_reg.pkt_length);
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        e_found_next = e_found_reg;
        e_idx_next   = e_idx_reg;
        r_found_next = r_found_reg;
        r_idx_next   = r_idx_reg;
        hit_next     = hit_reg;
        valid_next   = valid_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        flush        = 1'b0;
        new_res      = '0;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = '0;
        fwe          = 1'b0;
        fwa          = '0;
        fwd          = 1'b0;
        rfwe         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    cur_next     = q_data;
                    idx_next     = '0;
                    e_found_next = 1'b0;
                    r_found_next = 1'b0;
                    state_next   = q_data.sweep ? ST_SW_RD : ST_LK_RD;
                end
            end
            ST_SW_RD:
            begin
                if (at_end)
                begin
                    idx_next   = '0;
                    state_next = cur_reg.udp ? ST_LK_RD : ST_FIN;
                end
                else if (!valid_reg[idx])
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                new_res.kind      = KIND_DELETED;
                new_res.addrs     = rd_data_reg.addrs;
                new_res.ports     = rd_data_reg.ports;
                new_res.full      = full_reg[idx];
                new_res.rev       = rd_data_reg.rev;
                new_res.packets   = rd_data_reg.packets;
                new_res.bytes     = rd_data_reg.bytes;
                new_res.first     = rd_data_reg.first;
                new_res.last_seen = rd_data_reg.last;
                if (!expired)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
                else if (can_emit)
                begin
                    emit            = 1'b1;
                    valid_next[idx] = 1'b0;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = ST_SW_RD;
                end
            end
            ST_LK_RD:
            begin
                if (at_end)
                    state_next = ST_LK_DONE;
                else if (!valid_reg[idx])
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = ST_LK_CHK;
            end
            ST_LK_CHK:
            begin
                if (!e_found_reg && rd_data_reg.addrs == key_a && rd_data_reg.ports == key_p)
                begin
                    e_found_next = 1'b1;
                    e_idx_next   = idx;
                    hit_next     = rd_data_reg;
                end
                if (!r_found_reg && rd_data_reg.addrs == rkey_a
                    && rd_data_reg.ports == rkey_p)
                begin
                    r_found_next = 1'b1;
                    r_idx_next   = idx;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_LK_RD;
            end
            ST_LK_DONE:
            begin
                new_res.addrs = key_a;
                new_res.ports = key_p;
                if (e_found_reg)
                    state_next = ST_UPD;
                else if (!free_found)
                begin
                    new_res.kind = KIND_UNTRACKED;
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    new_res.kind      = KIND_CREATED;
                    new_res.full      = r_found_reg;
                    new_res.rev       = r_found_reg;
                    new_res.first     = cur_reg.time_sec;
                    new_res.last_seen = cur_reg.time_sec;
                    if (can_emit)
                    begin
                        emit                 = 1'b1;
                        mem_we               = 1'b1;
                        mem_wa               = free_idx;
                        mem_wd.addrs         = key_a;
                        mem_wd.ports         = key_p;
                        mem_wd.rev           = r_found_reg;
                        mem_wd.packets       = '0;
                        mem_wd.bytes         = '0;
                        mem_wd.first         = cur_reg.time_sec;
                        mem_wd.last          = cur_reg.time_sec;
                        hit_next             = mem_wd;
                        e_idx_next           = free_idx;
                        valid_next[free_idx] = 1'b1;
                        fwe                  = 1'b1;
                        fwa                  = free_idx;
                        fwd                  = r_found_reg;
                        rfwe                 = r_found_reg;
                        state_next           = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                new_res.kind      = KIND_COUNTED;
                new_res.addrs     = upd.addrs;
                new_res.ports     = upd.ports;
                new_res.full      = full_reg[e_idx_reg];
                new_res.rev       = upd.rev;
                new_res.packets   = upd.packets;
                new_res.bytes     = upd.bytes;
                new_res.first     = upd.first;
                new_res.last_seen = upd.last;
                if (can_emit)
                begin
                    emit       = 1'b1;
                    mem_we     = 1'b1;
                    mem_wa     = e_idx_reg;
                    mem_wd     = upd;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // one result is held back until the next one is known, so last can be set
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && res_stall;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (emit)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
        end
        else if (flush)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
            full_reg[fwa] <= fwd;
        if (rfwe)
            full_reg[r_idx_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        hit_reg  <= hit_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        e_idx_reg <= e_idx_next;
        r_idx_reg <= r_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            e_found_reg    <= 1'b0;
            r_found_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            e_found_reg    <= e_found_next;
            r_found_reg    <= r_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
    end

endmodule

>>> sv/udp_flow_tracker_core.sv
// top level of the udp flow tracker: front end, queue and table back end
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  in       in         in_valid/in_stall     has_ip .. pkt_length
//  out      out        out_valid/out_stall   kind .. last
//
// the back pops an item, then for the aging sweep and again for the lookup
// walks the table, skipping free entries and reading then checking each valid
// entry and ending the walk, then creates, counts and flushes as needed;
// the single table read port makes each walk visit one entry at a time
// the front accepts items into a two-deep queue while the back is busy
// reset clears valid bits and the aging time mark and sets the config registers to their defaults at once
// out_stall only holds the back when a second result is ready to leave
module udp_flow_tracker_core #(
    parameter int FLOW_ENTRIES = ufl_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ufl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          has_ip,
    input  logic                          has_udp,
    input  logic [31:0]                   src_ip,
    input  logic [15:0]                   src_port,
    input  logic [31:0]                   dst_ip,
    input  logic [15:0]                   dst_port,
    input  logic [31:0]                   time_sec,
    input  logic [15:0]                   pkt_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [31:0]                   flow_src_ip,
    output logic [15:0]                   flow_src_port,
    output logic [31:0]                   flow_dst_ip,
    output logic [15:0]                   flow_dst_port,
    output logic                          flow_full,
    output logic                          server_to_client,
    output logic [31:0]                   packet_count,
    output logic [47:0]                   byte_count,
    output logic [31:0]                   first_seen,
    output logic [31:0]                   last_seen,
    output logic                          last
);
    import ufl_pkg::*;

    tmo_t tmo;
    cmd_t push_data;
    cmd_t pop_data;
    res_t res;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // front: config, aging trigger, udp classification
    ufl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .has_ip     (has_ip),
        .has_udp    (has_udp),
        .src_ip     (src_ip),
        .src_port   (src_port),
        .dst_ip     (dst_ip),
        .dst_port   (dst_port),
        .time_sec   (time_sec),
        .pkt_length (pkt_length),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data),
        .tmo        (tmo)
    );

    // decouples packet intake from the table walk
    ufl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: table sweep, lookup, create and count
    ufl_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tmo       (tmo),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    // unpack the result item onto the output ports
    always_comb
    begin
        kind             = res.kind;
        flow_src_ip      = res.addrs[63:32];
        flow_dst_ip      = res.addrs[31:0];
        flow_src_port    = res.ports[31:16];
        flow_dst_port    = res.ports[15:0];
        flow_full        = res.full;
        server_to_client = res.rev;
        packet_count     = res.packets;
        byte_count       = res.bytes;
        first_seen       = res.first;
        last_seen        = res.last_seen;
        last             = res.last;
    end

endmodule

>>> sv/ufl_checker.sv
// port level checks of the udp flow tracker and their bind
module ufl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    kind,
    input logic                          flow_full,
    input logic                          server_to_client,
    input logic [31:0]                   packet_count,
    input logic [47:0]                   byte_count,
    input logic [31:0]                   first_seen,
    input logic [31:0]                   last_seen,
    input logic                          last
);
    import ufl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

    a_untracked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_UNTRACKED |-> last && packet_count == 32'd0
        && byte_count == 48'd0 && !flow_full && !server_to_client)
        else $error("bad untracked item");

    a_created: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CREATED |-> !last && packet_count == 32'd0
        && first_seen == last_seen && flow_full == server_to_client)
        else $error("bad created item");

    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_COUNTED |-> last && packet_count != 32'd0)
        else $error("bad counted item");

endmodule

bind udp_flow_tracker_core ufl_checker u_ufl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .flow_full        (flow_full),
    .server_to_client (server_to_client),
    .packet_count     (packet_count),
    .byte_count       (byte_count),
    .first_seen       (first_seen),
    .last_seen        (last_seen),
    .last             (last)
);
